[src/acc32_pkg.sv]
package acc32_pkg;

    localparam int unsigned MEM_WORDS = 32;
    localparam int unsigned ADDR_W = $clog2(MEM_WORDS);
    localparam int unsigned DATA_W = 8;
    localparam int unsigned OP_W = DATA_W - ADDR_W;
    localparam int unsigned EXEC_CNT_W = 20;

    typedef enum logic [OP_W-1:0] {
        OP_STORE = 3'd0,
        OP_LOAD  = 3'd1,
        OP_BRZ   = 3'd2,
        OP_NOP   = 3'd3,
        OP_DEC   = 3'd4,
        OP_INC   = 3'd5,
        OP_JMP   = 3'd6,
        OP_HALT  = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_DECODE,
        ST_LOAD_ACC,
        ST_HALT_WAIT
    } state_t;

    typedef enum logic [1:0] {
        ADDR_LOAD,
        ADDR_PC,
        ADDR_OPER
    } addr_sel_t;

    typedef struct packed {
        addr_sel_t addr_sel;
        logic      load_write;
        logic      clear_run;
        logic      exec;
        logic      load_acc;
        logic      emit;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic last_slot;
        logic wd_end;
        logic out_free;
    } status_t;

endpackage

[src/accumulator_cpu_32_byte.sv]
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   mem_byte  (8 bits, one memory word)
// output    out        out_valid / out_stall acc_value (8 bits, accumulator at halt)
//
// Loading takes one word per cycle; the 32nd word starts the program at address 0.
// Each instruction is fetched from the single RAM port and then executed (ST_FETCH, ST_DECODE),
// and a load adds an ST_LOAD_ACC step for its operand read.
// A watchdog ends a run after 2^20 instructions without a result.
// The input stalls while the program runs; reset clears the controller and all counters.
// A halt waits while the output register holds an untaken word.
module accumulator_cpu_32_byte (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [acc32_pkg::DATA_W-1:0] mem_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [acc32_pkg::DATA_W-1:0] acc_value
);

    acc32_pkg::cmd_t    cmd;
    acc32_pkg::status_t status;

    acc32_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    acc32_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .mem_byte (mem_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .acc_value(acc_value),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

[src/acc32_ram.sv]
module acc32_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[src/acc32_ctrl.sv]
module acc32_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  acc32_pkg::status_t status,
    output acc32_pkg::cmd_t    cmd
);

    acc32_pkg::state_t state_reg;
    acc32_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acc32_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_stall       = 1'b1;
        cmd            = '0;
        cmd.addr_sel   = acc32_pkg::ADDR_PC;
        unique case (state_reg)
            acc32_pkg::ST_LOAD:
            begin
                in_stall       = 1'b0;
                cmd.addr_sel   = acc32_pkg::ADDR_LOAD;
                cmd.load_write = in_valid;
                if (in_valid && status.last_slot)
                begin
                    cmd.clear_run = 1'b1;
                    state_next    = acc32_pkg::ST_FETCH;
                end
            end
            acc32_pkg::ST_FETCH:
            begin
                state_next = acc32_pkg::ST_DECODE;
            end
            acc32_pkg::ST_DECODE:
            begin
                cmd.addr_sel = acc32_pkg::ADDR_OPER;
                if (status.op == acc32_pkg::OP_HALT)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = acc32_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = acc32_pkg::ST_HALT_WAIT;
                    end
                end
                else
                begin
                    cmd.exec = 1'b1;
                    if (status.wd_end)
                    begin
                        state_next = acc32_pkg::ST_LOAD;
                    end
                    else if (status.op == acc32_pkg::OP_LOAD)
                    begin
                        state_next = acc32_pkg::ST_LOAD_ACC;
                    end
                    else
                    begin
                        state_next = acc32_pkg::ST_FETCH;
                    end
                end
            end
            acc32_pkg::ST_LOAD_ACC:
            begin
                cmd.load_acc = 1'b1;
                state_next   = acc32_pkg::ST_FETCH;
            end
            acc32_pkg::ST_HALT_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = acc32_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = acc32_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

[src/acc32_dp.sv]
module acc32_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [acc32_pkg::DATA_W-1:0]   mem_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [acc32_pkg::DATA_W-1:0]   acc_value,
    input  acc32_pkg::cmd_t                cmd,
    output acc32_pkg::status_t             status
);

    logic [acc32_pkg::ADDR_W-1:0]     load_count_reg;
    logic [acc32_pkg::ADDR_W-1:0]     load_count_next;
    logic [acc32_pkg::ADDR_W-1:0]     pc_reg;
    logic [acc32_pkg::ADDR_W-1:0]     pc_next;
    logic [acc32_pkg::DATA_W-1:0]     acc_reg;
    logic [acc32_pkg::DATA_W-1:0]     acc_next;
    logic [acc32_pkg::EXEC_CNT_W-1:0] wd_reg;
    logic [acc32_pkg::EXEC_CNT_W-1:0] wd_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [acc32_pkg::DATA_W-1:0]     out_data_reg;

    logic                             ram_we;
    logic [acc32_pkg::ADDR_W-1:0]     ram_addr;
    logic [acc32_pkg::DATA_W-1:0]     ram_wdata;
    logic [acc32_pkg::DATA_W-1:0]     ram_rdata;
    logic [acc32_pkg::ADDR_W-1:0]     oper_addr;
    acc32_pkg::op_t                   op;

    assign op        = acc32_pkg::op_t'(ram_rdata[acc32_pkg::DATA_W-1:acc32_pkg::ADDR_W]);
    assign oper_addr = ram_rdata[acc32_pkg::ADDR_W-1:0];

    acc32_ram #(
        .WIDTH(acc32_pkg::DATA_W),
        .DEPTH(acc32_pkg::MEM_WORDS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        unique case (cmd.addr_sel)
            acc32_pkg::ADDR_LOAD: ram_addr = load_count_reg;
            acc32_pkg::ADDR_PC:   ram_addr = pc_reg;
            acc32_pkg::ADDR_OPER: ram_addr = oper_addr;
            default:              ram_addr = pc_reg;
        endcase
        ram_we    = cmd.load_write || (cmd.exec && (op == acc32_pkg::OP_STORE));
        ram_wdata = cmd.load_write ? mem_byte : acc_reg;
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        pc_next         = pc_reg;
        acc_next        = acc_reg;
        wd_next         = wd_reg;
        if (cmd.load_write)
        begin
            load_count_next = load_count_reg + acc32_pkg::ADDR_W'(1);
        end
        if (cmd.clear_run)
        begin
            pc_next  = '0;
            acc_next = '0;
            wd_next  = '0;
        end
        if (cmd.load_acc)
        begin
            acc_next = ram_rdata;
        end
        if (cmd.exec)
        begin
            wd_next = wd_reg + acc32_pkg::EXEC_CNT_W'(1);
            pc_next = pc_reg + acc32_pkg::ADDR_W'(1);
            unique case (op)
                acc32_pkg::OP_BRZ:
                begin
                    if (acc_reg == '0)
                    begin
                        pc_next = oper_addr;
                    end
                end
                acc32_pkg::OP_JMP: pc_next  = oper_addr;
                acc32_pkg::OP_DEC: acc_next = acc_reg - acc32_pkg::DATA_W'(1);
                acc32_pkg::OP_INC: acc_next = acc_reg + acc32_pkg::DATA_W'(1);
                acc32_pkg::OP_STORE,
                acc32_pkg::OP_LOAD,
                acc32_pkg::OP_NOP,
                acc32_pkg::OP_HALT:
                begin
                end
                default:
                begin
                end
            endcase
        end
        out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            pc_reg         <= '0;
            acc_reg        <= '0;
            wd_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            pc_reg         <= pc_next;
            acc_reg        <= acc_next;
            wd_reg         <= wd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= acc_reg;
        end
    end

    assign status.op        = op;
    assign status.last_slot = (load_count_reg == acc32_pkg::ADDR_W'(acc32_pkg::MEM_WORDS - 1));
    assign status.wd_end    = (wd_reg == '1);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign acc_value = out_data_reg;

endmodule

[bench/tb_accumulator_cpu_32_byte.sv]
module tb_accumulator_cpu_32_byte;

    localparam int unsigned WD_STEPS    = 1 << acc32_pkg::EXEC_CNT_W;
    localparam int unsigned TRIAL_STEPS = 400;
    localparam int unsigned NUM_ROWS    = 11;
    localparam int unsigned RAND_PROGS  = 48;
    localparam int unsigned DRAIN       = 60;

    typedef logic [acc32_pkg::MEM_WORDS-1:0][acc32_pkg::DATA_W-1:0] mem_image_t;

    typedef struct {
        mem_image_t                    image;
        bit                            typed;
        bit                            halts;
        logic [acc32_pkg::DATA_W-1:0]  acc;
    } dir_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [acc32_pkg::DATA_W-1:0] mem_byte;
    logic                         out_valid;
    logic                         out_stall;
    logic [acc32_pkg::DATA_W-1:0] acc_value;

    logic [acc32_pkg::DATA_W-1:0] halt_acc_q[$];
    mem_image_t                   loaded_image;
    logic [acc32_pkg::ADDR_W-1:0] load_slot;
    int                           fail_cnt;
    bit                           calm;

    accumulator_cpu_32_byte uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mem_byte  (mem_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .acc_value (acc_value)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [acc32_pkg::DATA_W-1:0] ins(input acc32_pkg::op_t op,
                                                         input int unsigned a);
        return {op, acc32_pkg::ADDR_W'(a)};
    endfunction

    function automatic bit execute_image(input mem_image_t img, input int unsigned limit,
                                         output logic [acc32_pkg::DATA_W-1:0] acc);
        logic [acc32_pkg::ADDR_W-1:0] pc;
        logic [acc32_pkg::DATA_W-1:0] w;
        logic [acc32_pkg::ADDR_W-1:0] a;
        acc32_pkg::op_t               op;
        int unsigned                  n;
        acc = '0;
        pc = '0;
        for (n = 0; n < limit; n++)
        begin
            w = img[pc];
            op = acc32_pkg::op_t'(w[acc32_pkg::DATA_W-1:acc32_pkg::ADDR_W]);
            a = w[acc32_pkg::ADDR_W-1:0];
            pc = pc + acc32_pkg::ADDR_W'(1);
            case (op)
                acc32_pkg::OP_STORE: img[a] = acc;
                acc32_pkg::OP_LOAD:  acc = img[a];
                acc32_pkg::OP_BRZ:   if (acc == '0) pc = a;
                acc32_pkg::OP_NOP:   ;
                acc32_pkg::OP_DEC:   acc = acc - acc32_pkg::DATA_W'(1);
                acc32_pkg::OP_INC:   acc = acc + acc32_pkg::DATA_W'(1);
                acc32_pkg::OP_JMP:   pc = a;
                acc32_pkg::OP_HALT:  return 1'b1;
            endcase
        end
        return 1'b0;
    endfunction

    function automatic bit absorb_byte(input logic [acc32_pkg::DATA_W-1:0] b,
                                       output logic [acc32_pkg::DATA_W-1:0] acc);
        acc = '0;
        loaded_image[load_slot] = b;
        if (load_slot != acc32_pkg::ADDR_W'(acc32_pkg::MEM_WORDS - 1))
        begin
            load_slot = load_slot + acc32_pkg::ADDR_W'(1);
            return 1'b0;
        end
        load_slot = '0;
        return execute_image(loaded_image, WD_STEPS, acc);
    endfunction

    function automatic dir_row_t dir_row(input int idx);
        dir_row_t r;
        r.typed = 1'b0;
        r.halts = 1'b1;
        r.acc = '0;
        r.image = {acc32_pkg::MEM_WORDS{ins(acc32_pkg::OP_NOP, 0)}};
        case (idx)
            0:
            begin
                r.image = {acc32_pkg::MEM_WORDS{8'hFF}};
                r.typed = 1'b1;
                r.acc = 8'd0;
            end
            1:
            begin
                r.image = {acc32_pkg::MEM_WORDS{8'h00}};
                r.image[0] = ins(acc32_pkg::OP_DEC, 0);
                r.image[1] = ins(acc32_pkg::OP_HALT, 0);
                r.typed = 1'b1;
                r.acc = 8'd255;
            end
            2:
            begin
                r.image = {acc32_pkg::MEM_WORDS{ins(acc32_pkg::OP_HALT, 0)}};
                r.image[0] = ins(acc32_pkg::OP_INC, 0);
                r.image[1] = ins(acc32_pkg::OP_INC, 0);
                r.image[2] = ins(acc32_pkg::OP_INC, 0);
                r.typed = 1'b1;
                r.acc = 8'd3;
            end
            3:
            begin
                r.image[0] = ins(acc32_pkg::OP_LOAD, 31);
                r.image[1] = ins(acc32_pkg::OP_HALT, 0);
                r.image[31] = 8'hFF;
                r.typed = 1'b1;
                r.acc = 8'd255;
            end
            4:
            begin
                r.image[0] = ins(acc32_pkg::OP_LOAD, 31);
                r.image[1] = ins(acc32_pkg::OP_INC, 0);
                r.image[2] = ins(acc32_pkg::OP_HALT, 0);
                r.image[31] = 8'hFF;
                r.typed = 1'b1;
                r.acc = 8'd0;
            end
            5:
            begin
                r.image = {acc32_pkg::MEM_WORDS{ins(acc32_pkg::OP_HALT, 0)}};
                r.image[0] = ins(acc32_pkg::OP_BRZ, 5);
                r.image[1] = ins(acc32_pkg::OP_INC, 0);
                r.image[5] = ins(acc32_pkg::OP_INC, 0);
                r.image[6] = ins(acc32_pkg::OP_INC, 0);
                r.typed = 1'b1;
                r.acc = 8'd2;
            end
            6:
            begin
                r.image = {acc32_pkg::MEM_WORDS{ins(acc32_pkg::OP_HALT, 0)}};
                r.image[0] = ins(acc32_pkg::OP_INC, 0);
                r.image[1] = ins(acc32_pkg::OP_BRZ, 5);
                r.image[2] = ins(acc32_pkg::OP_INC, 0);
                r.typed = 1'b1;
                r.acc = 8'd2;
            end
            7:
            begin
                r.image[0] = ins(acc32_pkg::OP_BRZ, 30);
                r.image[1] = ins(acc32_pkg::OP_HALT, 0);
                r.image[30] = ins(acc32_pkg::OP_INC, 0);
                r.image[31] = ins(acc32_pkg::OP_INC, 0);
                r.typed = 1'b1;
                r.acc = 8'd2;
            end
            8:
            begin
                r.image = {acc32_pkg::MEM_WORDS{ins(acc32_pkg::OP_INC, 0)}};
                r.image[0] = ins(acc32_pkg::OP_LOAD, 20);
                r.image[1] = ins(acc32_pkg::OP_STORE, 3);
                r.image[2] = ins(acc32_pkg::OP_LOAD, 21);
                r.image[3] = ins(acc32_pkg::OP_NOP, 0);
                r.image[10] = ins(acc32_pkg::OP_HALT, 0);
                r.image[20] = ins(acc32_pkg::OP_HALT, 0);
                r.image[21] = 8'h5A;
            end
            9:
            begin
                r.image = {acc32_pkg::MEM_WORDS{ins(acc32_pkg::OP_JMP, 0)}};
                r.typed = 1'b1;
                r.halts = 1'b0;
            end
            default:
            begin
                r.image[0] = ins(acc32_pkg::OP_DEC, 0);
                r.image[1] = ins(acc32_pkg::OP_DEC, 0);
                r.image[2] = ins(acc32_pkg::OP_STORE, 31);
                r.image[3] = ins(acc32_pkg::OP_LOAD, 30);
                r.image[4] = ins(acc32_pkg::OP_INC, 0);
                r.image[5] = ins(acc32_pkg::OP_STORE, 30);
                r.image[6] = ins(acc32_pkg::OP_LOAD, 31);
                r.image[7] = ins(acc32_pkg::OP_BRZ, 0);
                r.image[8] = ins(acc32_pkg::OP_HALT, 0);
                r.image[30] = 8'h7F;
                r.image[31] = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [acc32_pkg::DATA_W-1:0] b, input bit typed);
        int unsigned                  gap;
        logic [acc32_pkg::DATA_W-1:0] acc;
        bit                           halted;
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mem_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        halted = absorb_byte(b, acc);
        if (halted && !typed)
            halt_acc_q.push_back(acc);
    endtask

    task automatic send_image(input mem_image_t img, input bit typed, input bit t_halts,
                              input logic [acc32_pkg::DATA_W-1:0] t_acc);
        int i;
        calm = ($urandom_range(0, 4) == 0);
        for (i = 0; i < acc32_pkg::MEM_WORDS; i++)
            send_word(img[i], typed);
        if (typed && t_halts)
            halt_acc_q.push_back(t_acc);
    endtask

    initial
    begin
        dir_row_t                     row;
        mem_image_t                   img;
        logic [acc32_pkg::DATA_W-1:0] scratch;
        logic [acc32_pkg::OP_W-1:0]   opc;
        logic [acc32_pkg::ADDR_W-1:0] a;
        int                           n;
        int                           i;
        int                           code_len;
        bit                           noise;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mem_byte = '0;
        fail_cnt = 0;
        calm = 1'b0;
        loaded_image = '0;
        load_slot = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < NUM_ROWS; n++)
        begin
            row = dir_row(n);
            send_image(row.image, row.typed, row.halts, row.acc);
        end

        // Random programs are kept only if they halt soon, so that runs stay short.
        for (n = 0; n < RAND_PROGS; n++)
        begin
            do
            begin
                noise = ($urandom_range(0, 3) == 0);
                code_len = $urandom_range(2, 28);
                for (i = 0; i < acc32_pkg::MEM_WORDS; i++)
                begin
                    if (noise || i >= code_len)
                        img[i] = acc32_pkg::DATA_W'($urandom);
                    else if (i == code_len - 1)
                        img[i] = ins(acc32_pkg::OP_HALT,
                                     $urandom_range(0, acc32_pkg::MEM_WORDS - 1));
                    else
                    begin
                        opc = acc32_pkg::OP_W'($urandom_range(0, 7));
                        a = acc32_pkg::ADDR_W'($urandom);
                        case (acc32_pkg::op_t'(opc))
                            acc32_pkg::OP_LOAD, acc32_pkg::OP_STORE:
                                if ($urandom_range(0, 7) != 0)
                                    a = acc32_pkg::ADDR_W'($urandom_range(
                                            code_len, acc32_pkg::MEM_WORDS - 1));
                            acc32_pkg::OP_BRZ, acc32_pkg::OP_JMP:
                                if ($urandom_range(0, 7) != 0)
                                    a = acc32_pkg::ADDR_W'($urandom_range(
                                            i + 1, code_len - 1));
                            default: ;
                        endcase
                        img[i] = {opc, a};
                    end
                end
            end
            while (!execute_image(img, TRIAL_STEPS, scratch));
            send_image(img, 1'b0, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (halt_acc_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        fail_cnt = fail_cnt + halt_acc_q.size();
        if (fail_cnt == 0)
            $display("tb_accumulator_cpu_32_byte passed");
        else
            $display("tb_accumulator_cpu_32_byte failed");
        $finish;
    end

    initial
    begin
        logic [acc32_pkg::DATA_W-1:0] want;
        int unsigned                  stall_left;
        out_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (halt_acc_q.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("acc_value %0d arrived with no halt pending", acc_value);
                    fail_cnt++;
                end
                else
                begin
                    want = halt_acc_q.pop_front();
                    if (acc_value !== want)
                    begin
                        if (fail_cnt < 10)
                            $display("acc_value mismatch: expected %0d, got %0d",
                                     want, acc_value);
                        fail_cnt++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    initial
    begin
        #150_000_000;
        $display("tb_accumulator_cpu_32_byte failed");
        $finish;
    end

endmodule
